/* rtl/core/sts_pkg.sv */
// ----------------------------------------------------------------------------
// sts_pkg: shared types and codes of the sorted timeout scheduler.
// Input and result structs, register indexes and the back-end state type.
// ----------------------------------------------------------------------------
package sts_pkg;

	localparam int DATA_W = 32;
	localparam int HANDLE_W = 8;
	localparam int CFG_W = 16;
	localparam int MAX_FIRE = 16;

	localparam logic [0:0] REG_LEAD_MIN = 1'b0;
	localparam logic [0:0] REG_LATE_WINDOW = 1'b1;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	typedef struct packed {
		logic                mode;
		logic [DATA_W-1:0]   now_time;
		logic [DATA_W-1:0]   deadline;
		logic [HANDLE_W-1:0] handle;
	} sts_in_t;

	typedef struct packed {
		logic                fired_valid;
		logic [HANDLE_W-1:0] fired_handle;
		logic [DATA_W-1:0]   compare_value;
		logic                compare_armed;
		logic                insert_rejected;
		logic                last;
	} sts_out_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FREE,
		ST_WALK,
		ST_LINK,
		ST_TCHK,
		ST_FIRE,
		ST_FNEXT,
		ST_ARM,
		ST_EMIT,
		ST_WAIT
	} sts_state_t;

endpackage

/* rtl/core/sts_fifo.sv */
// ----------------------------------------------------------------------------
// sts_fifo: two-entry queue between the front and the back of the scheduler.
// Holds accepted input items so the front can take a transfer while busy.
// ----------------------------------------------------------------------------
module sts_fifo
	import sts_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_valid,
	output logic    wr_ready,
	input  sts_in_t wr_data,
	output logic    rd_valid,
	input  logic    rd_ready,
	output sts_in_t rd_data
);

	sts_in_t    mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr_valid && wr_ready) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_valid && wr_ready) begin
				wp_q <= ~wp_q;
			end
			if (rd_valid && rd_ready) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, wr_valid && wr_ready} - {1'b0, rd_valid && rd_ready};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !wr_ready) else $error("queue overflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd0 |-> !rd_valid) else $error("read from empty queue");
`endif

endmodule

/* rtl/core/sts_engine.sv */
// ----------------------------------------------------------------------------
// sts_engine: back end that walks the linked timeout table and drives results.
// Carries out inserts and ticks one step a cycle; results wait for res_ready.
// ----------------------------------------------------------------------------
module sts_engine
	import sts_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] lead_min,
	input  logic [CFG_W-1:0] late_window,
	input  logic             item_valid,
	output logic             item_ready,
	input  sts_in_t          item,
	output logic             res_valid,
	input  logic             res_ready,
	output sts_out_t         res
);

	localparam int IW = $clog2(SLOTS);
	localparam int LW = IW + 1;
	localparam logic [LW-1:0] NIL = LW'(SLOTS);
	localparam int CW = $clog2(MAX_FIRE + 1);

	logic [DATA_W-1:0]   dl_mem [SLOTS];
	logic [HANDLE_W-1:0] hd_mem [SLOTS];
	logic [LW-1:0]       lk_mem [SLOTS];
	logic [SLOTS-1:0]    busy_q;

	logic [LW-1:0]       head_q;
	logic [IW-1:0]       fptr_q;
	logic [DATA_W-1:0]   cmp_q;
	logic                armed_q;

	sts_state_t          st_q, st_d;
	sts_in_t             it_q;
	logic [IW-1:0]       p_q;
	logic [LW-1:0]       cnt_q;
	logic [LW-1:0]       prev_q, cur_q;
	logic [CW-1:0]       nf_q;
	logic [HANDLE_W-1:0] fh_q [MAX_FIRE];
	logic [CW-1:0]       ek_q;
	logic                rej_q;
	logic                emfire_q;

	logic [IW-1:0]       cur_i;
	logic [IW-1:0]       head_i;
	logic [IW-1:0]       p_nx;
	logic [DATA_W-1:0]   arm_then;
	logic [DATA_W-1:0]   arm_diff;
	logic [DATA_W:0]     arm_lim;
	logic [LW-1:0]       nxt_head;

	assign cur_i = cur_q[IW-1:0];
	assign head_i = head_q[IW-1:0];
	assign p_nx = (p_q == IW'(SLOTS - 1)) ? '0 : p_q + 1'b1;
	assign arm_then = dl_mem[head_i];
	assign arm_diff = arm_then - it_q.now_time + {16'd0, late_window};
	assign arm_lim = {17'd0, late_window} + {17'd0, lead_min};
	assign nxt_head = (lk_mem[head_i] < NIL) ? lk_mem[head_i] : NIL;

	always_comb begin
		st_d = st_q;
		item_ready = 1'b0;
		res_valid = 1'b0;
		res.fired_valid = emfire_q;
		res.fired_handle = emfire_q ? fh_q[ek_q[CW-2:0]] : '0;
		res.compare_value = cmp_q;
		res.compare_armed = armed_q;
		res.insert_rejected = rej_q;
		res.last = emfire_q ? (ek_q + 1'b1 == nf_q) : 1'b1;
		case (st_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					st_d = (item.mode == MODE_TICK) ? ST_TCHK : ST_FREE;
				end
			end
			ST_FREE: begin
				if (!busy_q[p_q]) begin
					st_d = ST_WALK;
				end else if (cnt_q == LW'(SLOTS - 1)) begin
					st_d = ST_EMIT;
				end
			end
			ST_WALK: begin
				if (cur_q >= NIL || cnt_q == NIL
					|| (it_q.deadline - dl_mem[cur_i]) >> 31 != 0) begin
					st_d = ST_LINK;
				end
			end
			ST_LINK: st_d = (prev_q >= NIL) ? ST_ARM : ST_EMIT;
			ST_TCHK: begin
				if (!armed_q || head_q >= NIL || (it_q.now_time - cmp_q) >> 31 != 0) begin
					st_d = ST_EMIT;
				end else begin
					st_d = ST_FIRE;
				end
			end
			ST_FIRE: st_d = ST_FNEXT;
			ST_FNEXT: begin
				if (nf_q < CW'(MAX_FIRE) && head_q < NIL
					&& (dl_mem[head_i] - it_q.now_time) >> 31 != 0) begin
					st_d = ST_FIRE;
				end else begin
					st_d = ST_ARM;
				end
			end
			ST_ARM: st_d = ST_EMIT;
			ST_EMIT: begin
				res_valid = 1'b1;
				if (res_ready && res.last) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				it_q <= item;
				cnt_q <= '0;
				nf_q <= '0;
				ek_q <= '0;
				rej_q <= 1'b0;
				emfire_q <= 1'b0;
				prev_q <= NIL;
				cur_q <= head_q;
				p_q <= fptr_q;
			end
			ST_FREE: begin
				if (busy_q[p_q]) begin
					p_q <= p_nx;
					cnt_q <= cnt_q + 1'b1;
					rej_q <= (cnt_q == LW'(SLOTS - 1));
				end else begin
					cnt_q <= '0;
				end
			end
			ST_WALK: begin
				if (!(cur_q >= NIL || cnt_q == NIL
					|| (it_q.deadline - dl_mem[cur_i]) >> 31 != 0)) begin
					prev_q <= cur_q;
					cur_q <= lk_mem[cur_i];
					cnt_q <= cnt_q + 1'b1;
				end
			end
			ST_LINK: begin
				dl_mem[p_q] <= it_q.deadline;
				hd_mem[p_q] <= it_q.handle;
				lk_mem[p_q] <= (cur_q > NIL) ? NIL : cur_q;
				if (prev_q < NIL) begin
					lk_mem[prev_q[IW-1:0]] <= {1'b0, p_q};
				end
			end
			ST_TCHK: emfire_q <= (st_d == ST_FIRE);
			ST_FIRE: begin
				fh_q[nf_q[CW-2:0]] <= hd_mem[head_i];
				nf_q <= nf_q + 1'b1;
			end
			ST_EMIT: begin
				if (res_ready) begin
					ek_q <= ek_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			busy_q <= '0;
			head_q <= NIL;
			fptr_q <= '0;
			cmp_q <= '0;
			armed_q <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_LINK: begin
					fptr_q <= p_q;
					busy_q[p_q] <= 1'b1;
					if (prev_q >= NIL) begin
						head_q <= {1'b0, p_q};
					end
				end
				ST_FIRE: begin
					busy_q[head_i] <= 1'b0;
					head_q <= nxt_head;
				end
				ST_ARM: begin
					if (head_q >= NIL) begin
						armed_q <= 1'b0;
					end else begin
						armed_q <= 1'b1;
						cmp_q <= ({1'b0, arm_diff} < arm_lim)
							? it_q.now_time + {16'd0, lead_min} : arm_then;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_head_busy: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE && head_q < NIL |-> busy_q[head_i])
		else $error("head slot not busy");
	a_armed_head: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_IDLE |-> armed_q == (head_q < NIL))
		else $error("armed flag disagrees with table");
	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= CW'(MAX_FIRE)) else $error("too many expiries");
`endif

endmodule

/* rtl/core/sorted_timeout_scheduler_top.sv */
// An insert searches for a free slot, then walks the sorted list one entry a cycle to link it in;
// it is rejected when every slot is busy. A tick that finds entries due fires them, then arms
// the compare for the new head or disarms it. The back end takes one item at a time, the next
// only after the last result of the one before.
// Reset: asynchronous, active low; table empty, compare disarmed, registers at defaults.
// ----------------------------------------------------------------------------
// sorted_timeout_scheduler_top: sorted deadline timer queue.
// Configuration registers, input queue and table engine.
// ----------------------------------------------------------------------------
module sorted_timeout_scheduler_top
	import sts_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  sts_in_t          in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output sts_out_t         out_data
);

	logic [CFG_W-1:0] lead_min_q;
	logic [CFG_W-1:0] late_window_q;
	logic             q_valid;
	logic             q_ready;
	sts_in_t          q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_min_q <= CFG_W'(32);
			late_window_q <= CFG_W'(512);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LEAD_MIN: lead_min_q <= cfg_data;
				REG_LATE_WINDOW: late_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sts_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_data),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
	);

	sts_engine #(.SLOTS(SLOTS)) u_engine (
		.clk(clk), .arst_n(arst_n),
		.lead_min(lead_min_q), .late_window(late_window_q),
		.item_valid(q_valid), .item_ready(q_ready), .item(q_data),
		.res_valid(out_valid), .res_ready(out_ready), .res(out_data)
	);

endmodule
